@@ rtl/core/window_median_filter_core_defines.svh @@
// Assertion helpers for the median filter core checkers.
// All of them sample on i_clk; the gated forms drop out while i_rst_n is low.
`ifndef WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH
`define WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH

`define WMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define WMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define WMF_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/wmf_pkg.sv @@
package wmf_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_WIN_W     = 3;
    localparam int DEF_WIN_H     = 3;
    localparam int DEF_WIN_N     = 9;

    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int CMD_W       = 1;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;
    localparam int RST_WIDTH   = 640;
    localparam int RST_HEIGHT  = 480;

    // largest window side the control masks can describe
    localparam int WIN_MAX = 7;

    // median unit depth and output queue
    localparam int MED_LAT   = 3;
    localparam int OUT_DEPTH = 8;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam logic [CH_W-1:0]  PAD_CH  = 8'hFF;
    localparam logic [PIX_W-1:0] PAD_PIX = {PAD_CH, PAD_CH, PAD_CH};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_index;

    // window control traveling with an item; bit k/i marks a row/column inside the image
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [WIN_MAX-1:0] row_ok;
        logic [WIN_MAX-1:0] col_ok;
    } t_win_ctl;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } t_result;

    // odd window side actually used for a requested size
    function automatic int win_span(input int n);
        return 2 * ((n - 1) / 2) + 1;
    endfunction

endpackage

@@ rtl/core/wmf_line_store.sv @@
module wmf_line_store #(
    parameter int MAX_WIDTH = wmf_pkg::DEF_MAX_WIDTH,
    parameter int WIN_H     = wmf_pkg::DEF_WIN_H
) (
    input  logic                                     i_clk,
    input  logic                                     i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]             i_rd_addr,
    input  logic                                     i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]             i_wr_addr,
    input  logic [wmf_pkg::PIX_W-1:0]                i_pixel,
    output logic [wmf_pkg::win_span(WIN_H)-1:0][wmf_pkg::PIX_W-1:0] o_column
);
    import wmf_pkg::*;

    localparam int HALF_H = (WIN_H - 1) / 2;

    generate
        if (HALF_H > 0) begin : g_store
            localparam int LB_ROWS = 2 * HALF_H;

            // entry per column: slot j holds the pixel j+1 rows above the newest row
            logic [LB_ROWS-1:0][PIX_W-1:0] r_mem [MAX_WIDTH];
            logic [LB_ROWS-1:0][PIX_W-1:0] r_rd_data;
            logic [LB_ROWS-1:0][PIX_W-1:0] r_fwd_data;
            logic                          r_fwd_hit;
            logic [LB_ROWS-1:0][PIX_W-1:0] old_rows;
            logic [LB_ROWS-1:0][PIX_W-1:0] wr_rows;

            // a read issued on the edge that writes the same column takes the new word
            always_comb begin
                old_rows = r_fwd_hit ? r_fwd_data : r_rd_data;
                wr_rows[0] = i_pixel;
                for (int j = 1; j < LB_ROWS; j++) begin
                    wr_rows[j] = old_rows[j-1];
                end
                o_column[0] = i_pixel;
                for (int j = 1; j <= LB_ROWS; j++) begin
                    o_column[j] = old_rows[j-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_wr_en) begin
                    r_mem[i_wr_addr] <= wr_rows;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_rd_en) begin
                    r_rd_data  <= r_mem[i_rd_addr];
                    r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
                    r_fwd_data <= wr_rows;
                end
            end
        end else begin : g_single_row
            assign o_column[0] = i_pixel;
        end
    endgenerate

endmodule

@@ rtl/core/wmf_window.sv @@
module wmf_window #(
    parameter int WIN_W = wmf_pkg::DEF_WIN_W,
    parameter int WIN_H = wmf_pkg::DEF_WIN_H
) (
    input  logic                                                     i_clk,
    input  logic                                                     i_rst_n,
    input  logic                                                     i_shift,
    input  logic [wmf_pkg::win_span(WIN_H)-1:0][wmf_pkg::PIX_W-1:0]  i_column,
    input  wmf_pkg::t_win_ctl                                        i_ctl,
    output wmf_pkg::t_win_ctl                                        o_ctl,
    output logic [wmf_pkg::win_span(WIN_W)*wmf_pkg::win_span(WIN_H)-1:0][wmf_pkg::CH_W-1:0] o_blue,
    output logic [wmf_pkg::win_span(WIN_W)*wmf_pkg::win_span(WIN_H)-1:0][wmf_pkg::CH_W-1:0] o_green,
    output logic [wmf_pkg::win_span(WIN_W)*wmf_pkg::win_span(WIN_H)-1:0][wmf_pkg::CH_W-1:0] o_red
);
    import wmf_pkg::*;

    localparam int WW_E = win_span(WIN_W);
    localparam int WH_E = win_span(WIN_H);

    // column 0 is the newest (rightmost) one
    logic [WH_E-1:0][PIX_W-1:0] r_win [WW_E];
    t_win_ctl                   r_ctl;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win[0] <= i_column;
            for (int i = 1; i < WW_E; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // replace positions outside the image by padding
    always_comb begin
        logic [PIX_W-1:0] pix;
        pix = PAD_PIX;
        for (int i = 0; i < WW_E; i++) begin
            for (int k = 0; k < WH_E; k++) begin
                pix = (r_ctl.row_ok[k] && r_ctl.col_ok[i]) ? r_win[i][k] : PAD_PIX;
                o_blue[i*WH_E+k]  = pix[CH_W-1:0];
                o_green[i*WH_E+k] = pix[2*CH_W-1:CH_W];
                o_red[i*WH_E+k]   = pix[3*CH_W-1:2*CH_W];
            end
        end
    end

    assign o_ctl = r_ctl;

endmodule

@@ rtl/core/wmf_median.sv @@
module wmf_median #(
    parameter int WIN_N = wmf_pkg::DEF_WIN_N
) (
    input  logic                                  i_clk,
    input  logic [WIN_N-1:0][wmf_pkg::CH_W-1:0]   i_vals,
    output logic [wmf_pkg::CH_W-1:0]              o_med
);
    import wmf_pkg::*;

    localparam int RANK_W = $clog2(WIN_N + 1);
    localparam int MID    = WIN_N / 2;

    logic [WIN_N-1:0][CH_W-1:0] r_v1;
    logic [WIN_N-1:0][CH_W-1:0] r_v2;
    logic [WIN_N-1:0]           cmp   [WIN_N];
    logic [WIN_N-1:0]           r_cmp [WIN_N];
    logic [RANK_W-1:0]          r_rank [WIN_N];
    logic [CH_W-1:0]            sel;
    logic [CH_W-1:0]            r_med;

    // element j ranks below element i; ties broken by position
    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            for (int j = 0; j < WIN_N; j++) begin
                cmp[i][j] = (i_vals[j] < i_vals[i]) ||
                            ((j < i) && (i_vals[j] == i_vals[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1  <= i_vals;
        r_cmp <= cmp;
    end

    always_ff @(posedge i_clk) begin
        r_v2 <= r_v1;
        for (int i = 0; i < WIN_N; i++) begin
            r_rank[i] <= RANK_W'($countones(r_cmp[i]));
        end
    end

    // ranks form a permutation, so exactly one element sits in the middle
    always_comb begin
        sel = '0;
        for (int i = 0; i < WIN_N; i++) begin
            if (r_rank[i] == RANK_W'(MID)) begin
                sel = sel | r_v2[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_med <= sel;
    end

    assign o_med = r_med;

endmodule

@@ rtl/core/window_median_filter_core.sv @@
// Channel  Dir  Handshake                  Payload
// in       in   i_valid / o_stall          i_command, i_blue, i_green, i_red
// out      out  o_valid / i_stall          o_med_blue, o_med_green, o_med_red, o_frame_end
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle while o_stall is low; each item does one line store read and one
// write-back of its column. A result passes from the transfer that completes its window
// through the line store read, window shift, three median stages and the output queue.
// Reset (synchronous, active low) clears the counters and the output queue; geometry
// returns to 640 x 480.
// The output queue holds 8 results; o_stall rises only when 8 results are owed.
module window_median_filter_core #(
    parameter int MAX_WIDTH = wmf_pkg::DEF_MAX_WIDTH,
    parameter int WIN_W     = wmf_pkg::DEF_WIN_W,
    parameter int WIN_H     = wmf_pkg::DEF_WIN_H
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [wmf_pkg::CMD_W-1:0]        i_command,
    input  logic [wmf_pkg::CH_W-1:0]         i_blue,
    input  logic [wmf_pkg::CH_W-1:0]         i_green,
    input  logic [wmf_pkg::CH_W-1:0]         i_red,

    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [wmf_pkg::CH_W-1:0]         o_med_blue,
    output logic [wmf_pkg::CH_W-1:0]         o_med_green,
    output logic [wmf_pkg::CH_W-1:0]         o_med_red,
    output logic                             o_frame_end,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wmf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wmf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wmf_pkg::*;

    localparam int HALF_W = (WIN_W - 1) / 2;
    localparam int HALF_H = (WIN_H - 1) / 2;
    localparam int WW_E   = win_span(WIN_W);
    localparam int WH_E   = win_span(WIN_H);
    localparam int WIN_N  = WW_E * WH_E;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int LAG_W  = $clog2(HALF_H * MAX_WIDTH + HALF_W + 2);

    localparam int                 RST_W_EFF   = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam logic [WID_W-1:0]    RST_WIDTH_V = WID_W'(RST_W_EFF);
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT_V = HEIGHT_W'(RST_HEIGHT);

    // geometry and position
    logic [WID_W-1:0]       r_width;
    logic [HEIGHT_W-1:0]    r_height;
    logic [WID_W-1:0]       n_width;
    logic [HEIGHT_W-1:0]    n_height;
    logic [WIDTH_REG_W-1:0] cfg_width;
    logic [COL_W-1:0]       r_in_col;
    logic [COL_W-1:0]       r_out_col;
    logic [HEIGHT_W-1:0]    r_out_row;
    logic [LAG_W-1:0]       r_cnt;
    logic [LAG_W-1:0]       lag;

    logic acc;
    logic cfg_wr;
    logic emit;
    logic in_col_last;
    logic out_col_last;
    logic frame_last;

    // first pipeline stage
    logic                 r_s1_valid;
    logic [PIX_W-1:0]     r_s1_pixel;
    logic [COL_W-1:0]     r_s1_col;
    t_win_ctl             r_s1_ctl;
    t_win_ctl             n_ctl;
    t_win_ctl             win_in_ctl;
    t_win_ctl             win_ctl;

    logic [WH_E-1:0][PIX_W-1:0]  column;
    logic [WIN_N-1:0][CH_W-1:0]  win_blue;
    logic [WIN_N-1:0][CH_W-1:0]  win_green;
    logic [WIN_N-1:0][CH_W-1:0]  win_red;
    logic [CH_W-1:0]             med_blue;
    logic [CH_W-1:0]             med_green;
    logic [CH_W-1:0]             med_red;

    logic [MED_LAT-1:0] r_mv;
    logic [MED_LAT-1:0] r_ml;

    // output queue
    t_result            r_q_data [OUT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_q_cnt;
    logic [CNT_W-1:0]   r_used;
    logic               push;
    logic               pop;
    t_result            head;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign acc         = i_valid && !o_stall;

    assign lag          = LAG_W'(HALF_H * int'(r_width) + HALF_W);
    assign emit         = (r_cnt >= lag);
    assign in_col_last  = (int'(r_in_col) + 1 >= int'(r_width));
    assign out_col_last = (int'(r_out_col) == int'(r_width) - 1);
    assign frame_last   = emit && out_col_last && (int'(r_out_row) == int'(r_height) - 1);

    // zero geometry becomes 1 and a width above MAX_WIDTH clamps to MAX_WIDTH; width uses the low 11 bits
    assign cfg_width = i_cfg_data[WIDTH_REG_W-1:0];
    always_comb begin
        if (cfg_width == '0) begin
            n_width = WID_W'(1);
        end else if (int'(cfg_width) > MAX_WIDTH) begin
            n_width = WID_W'(MAX_WIDTH);
        end else begin
            n_width = WID_W'(cfg_width);
        end
        n_height = (i_cfg_data == '0) ? HEIGHT_W'(1) : i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH_V;
            r_height  <= RST_HEIGHT_V;
            r_in_col  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_cnt     <= '0;
        end else if (cfg_wr) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WIDTH:  r_width  <= n_width;
                CFG_HEIGHT: r_height <= n_height;
            endcase
            r_in_col  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_cnt     <= '0;
        end else if (acc) begin
            if (frame_last) begin
                r_in_col  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_cnt     <= '0;
            end else begin
                r_in_col <= in_col_last ? '0 : r_in_col + 1'b1;
                if (!emit) begin
                    r_cnt <= r_cnt + 1'b1;
                end else if (out_col_last) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    // row k of the window column is dy = HALF_H - k, column i is dx = HALF_W - i
    always_comb begin
        int row_pos;
        int col_pos;
        n_ctl       = '0;
        n_ctl.valid = emit;
        n_ctl.last  = frame_last;
        for (int k = 0; k < WH_E; k++) begin
            row_pos        = int'(r_out_row) + HALF_H - k;
            n_ctl.row_ok[k] = (row_pos >= 0) && (row_pos < int'(r_height));
        end
        for (int i = 0; i < WW_E; i++) begin
            col_pos        = int'(r_out_col) + HALF_W - i;
            n_ctl.col_ok[i] = (col_pos >= 0) && (col_pos < int'(r_width));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pixel <= {i_red, i_green, i_blue};
            r_s1_col   <= r_in_col;
            r_s1_ctl   <= n_ctl;
        end
    end

    always_comb begin
        win_in_ctl       = r_s1_ctl;
        win_in_ctl.valid = r_s1_valid && r_s1_ctl.valid;
    end

    wmf_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .WIN_H     (WIN_H)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (r_in_col),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_pixel   (r_s1_pixel),
        .o_column  (column)
    );

    wmf_window #(
        .WIN_W (WIN_W),
        .WIN_H (WIN_H)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (r_s1_valid),
        .i_column (column),
        .i_ctl    (win_in_ctl),
        .o_ctl    (win_ctl),
        .o_blue   (win_blue),
        .o_green  (win_green),
        .o_red    (win_red)
    );

    wmf_median #(.WIN_N(WIN_N)) u_median_blue (
        .i_clk  (i_clk),
        .i_vals (win_blue),
        .o_med  (med_blue)
    );

    wmf_median #(.WIN_N(WIN_N)) u_median_green (
        .i_clk  (i_clk),
        .i_vals (win_green),
        .o_med  (med_green)
    );

    wmf_median #(.WIN_N(WIN_N)) u_median_red (
        .i_clk  (i_clk),
        .i_vals (win_red),
        .o_med  (med_red)
    );

    // track results through the median stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else begin
            r_mv <= {r_mv[MED_LAT-2:0], win_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ml <= {r_ml[MED_LAT-2:0], win_ctl.last};
    end

    assign push = r_mv[MED_LAT-1];
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_data[r_wr_ptr] <= '{red: med_red, green: med_green, blue: med_blue,
                                    frame_end: r_ml[MED_LAT-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
            r_used   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_q_cnt <= r_q_cnt + 1'b1;
                2'b01:   r_q_cnt <= r_q_cnt - 1'b1;
                default: r_q_cnt <= r_q_cnt;
            endcase
            // count results owed: reserved at an input transfer that emits, released at output transfer
            case ({acc && emit, pop})
                2'b10:   r_used <= r_used + 1'b1;
                2'b01:   r_used <= r_used - 1'b1;
                default: r_used <= r_used;
            endcase
        end
    end

    assign o_stall = (r_used == CNT_W'(OUT_DEPTH));
    assign o_valid = (r_q_cnt != '0);

    assign head        = r_q_data[r_rd_ptr];
    assign o_med_blue  = head.blue;
    assign o_med_green = head.green;
    assign o_med_red   = head.red;
    assign o_frame_end = head.frame_end;

endmodule

@@ rtl/core/wmf_checker.sv @@
`include "window_median_filter_core_defines.svh"

module wmf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [wmf_pkg::CH_W-1:0]  o_med_blue,
    input logic [wmf_pkg::CH_W-1:0]  o_med_green,
    input logic [wmf_pkg::CH_W-1:0]  o_med_red,
    input logic                      o_frame_end
);

    // a stalled result stays put
    `WMF_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_med_blue) && $stable(o_med_green) && $stable(o_med_red) && $stable(o_frame_end), "stalled result changed")

    // input only backs up when the output queue already holds results
    `WMF_ASSERT_NOW(a_stall_needs_backlog, o_stall, o_valid, "input stalled with no result waiting")

    `WMF_ASSERT_RESET(a_reset_clears, !o_valid && !o_stall, "reset left result or stall pending")

endmodule

bind window_median_filter_core wmf_checker u_wmf_checker (.*);
